@@ hw/rtl/ven_pkg.sv @@
// Shared types and constants for the Euclidean norm block.
// Used by ven_front, ven_queue, ven_root and vector_euclidean_norm.
package ven_pkg;

  localparam int VALUE_W     = 24;
  localparam int KIND_W      = 2;
  localparam int SQ_W        = 2 * VALUE_W;
  localparam int SUM_W       = 64;
  localparam int NORM_W      = 32;
  localparam int ROOT_STEPS  = SUM_W / 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [KIND_W-1:0] KIND_NUMBER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } sum_req_t;

endpackage

@@ hw/rtl/ven_front.sv @@
// Front end: takes elements, squares their magnitude and accumulates the sum.
// Pushes the finished sum of each good list toward the queue. Uses ven_pkg.
module ven_front import ven_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,
  input  logic [KIND_W-1:0]  in_tuser,
  input  logic               in_tlast,
  output sum_req_t           push,
  input  logic               push_ready
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [SQ_W-1:0]    s1_sq_r;
  logic               s1_num_r;
  logic               s1_err_r;
  logic               s1_last_r;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic               bad_r, bad_nxt;

  logic [VALUE_W-1:0] mag;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_new;
  logic               bad_new;
  logic               s1_fire;
  logic               in_fire;

  assign mag = in_tdata[VALUE_W-1] ? (~in_tdata + {{(VALUE_W-1){1'b0}}, 1'b1}) : in_tdata;

  assign sum_ext = {1'b0, acc_r} + {{(SUM_W+1-SQ_W){1'b0}}, s1_sq_r};
  assign bad_new = bad_r | s1_err_r;

  always_comb begin
    if (!s1_num_r) begin
      sum_new = acc_r;
    end else if (sum_ext[SUM_W]) begin
      sum_new = '1;
    end else begin
      sum_new = sum_ext[SUM_W-1:0];
    end
  end

  assign s1_fire   = s1_valid_r && (!s1_last_r || bad_new || push_ready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign push.valid = s1_valid_r && s1_last_r && !bad_new;
  assign push.sum   = sum_new;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    acc_nxt      = acc_r;
    bad_nxt      = bad_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      if (s1_last_r) begin
        acc_nxt = '0;
        bad_nxt = 1'b0;
      end else begin
        acc_nxt = sum_new;
        bad_nxt = bad_new;
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
      bad_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      acc_r      <= acc_nxt;
      bad_r      <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sq_r   <= SQ_W'(mag) * SQ_W'(mag);
      s1_num_r  <= (in_tuser == KIND_NUMBER);
      s1_err_r  <= (in_tuser == KIND_SYMBOL) || (in_tuser == KIND_UNKNOWN);
      s1_last_r <= in_tlast;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (acc_r == '0 && !bad_r))
    else $error("accumulator not cleared after the last element");

  a_push_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (s1_last_r && !bad_r && !s1_err_r))
    else $error("sum pushed for a bad list");

endmodule

@@ hw/rtl/ven_queue.sv @@
// Small FIFO of finished sums between the front end and the root unit.
// Uses ven_pkg for the request type.
module ven_queue import ven_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sum_req_t push,
  output logic     push_ready,
  output sum_req_t pop,
  input  logic     pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop.valid  = (count_r != '0);
  assign pop.sum    = mem[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.sum;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond its depth");

endmodule

@@ hw/rtl/ven_root.sv @@
// Back end: integer square root of a sum, one result bit per cycle,
// followed by the output register. Uses ven_pkg.
module ven_root import ven_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sum_req_t          pop,
  output logic              pop_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [NORM_W-1:0] out_tdata
);

  localparam int STEP_W = $clog2(ROOT_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_STEPS - 1);
  localparam logic [SUM_W-1:0]  PROBE_INIT = {2'b01, {(SUM_W-2){1'b0}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  x_r, x_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [SUM_W-1:0]  probe_r, probe_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NORM_W-1:0] out_data_r;

  logic [SUM_W-1:0]  trial;
  logic              take;
  logic              out_free;
  logic              load_out;

  assign trial     = acc_r + probe_r;
  assign take      = (x_r >= trial);
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == ST_DONE) && out_free;
  assign pop_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    probe_nxt     = probe_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop.valid) begin
          state_nxt = ST_BUSY;
          step_nxt  = '0;
          x_nxt     = pop.sum;
          acc_nxt   = '0;
          probe_nxt = PROBE_INIT;
        end
      end
      ST_BUSY: begin
        if (take) begin
          x_nxt   = x_r - trial;
          acc_nxt = (acc_r >> 1) + probe_r;
        end else begin
          acc_nxt = acc_r >> 1;
        end
        probe_nxt = probe_r >> 2;
        step_nxt  = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    x_r     <= x_nxt;
    acc_r   <= acc_nxt;
    probe_r <= probe_nxt;
    if (load_out) begin
      out_data_r <= acc_r[NORM_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (acc_r[SUM_W-1:NORM_W] == '0))
    else $error("root wider than the result field");

  a_done_after_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY && step_r == LAST_STEP) |=> (state_r == ST_DONE))
    else $error("root unit did not finish after its last step");

endmodule

@@ hw/rtl/vector_euclidean_norm.sv @@
// Top level of the Euclidean norm block: front end, sum queue and root unit.
// Depends on ven_pkg, ven_front, ven_queue and ven_root.
//
//   channel  direction  payload
//   in_      slave      tdata = elem_value, tuser = elem_kind, tlast = is_last
//   out_     master     tdata = norm
//
// Elements are taken one per cycle; a list's sum is formed in the stage register
// holding its last element and pushed from there into the sum queue. The square
// root is worked out in a one-bit-per-step unit that takes a new sum only when
// idle and then loads the output register. The input stalls only when the sum
// queue is full at a list end. Reset clears the accumulator, queue and root unit.
module vector_euclidean_norm import ven_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [23:0] elem_value
  input  logic [KIND_W-1:0] in_tuser,    // [1:0] elem_kind
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [NORM_W-1:0] out_tdata    // [31:0] norm
);

  sum_req_t push;
  sum_req_t pop;
  logic     push_ready;
  logic     pop_ready;

  ven_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_ready (push_ready)
  );

  ven_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  ven_root u_root (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .pop_ready  (pop_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
